>>> hw/rtl/mpt_pkg.sv
// Shared types, operation codes and constants for the station presence table.
// Used by mpt_cell, mpt_proc and mac_presence_table_with_aging.
package mpt_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 64;
    localparam int unsigned ADDR_W            = 48;
    localparam int unsigned TTL_W             = 16;
    localparam int unsigned TIME_W            = 32;
    localparam int unsigned SLOT_W            = 6;

    localparam logic [1:0] OP_SIGHT = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [TTL_W-1:0]  TTL_RESET = 16'd60;
    localparam logic [TIME_W-1:0] TIME_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [TTL_W-1:0]  ttl;
        logic              offline;
        logic [TIME_W-1:0] online_time;
    } t_entry;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [TTL_W-1:0]  ttl_reload;
        logic              found;
    } t_proc_ctrl;

endpackage

>>> hw/rtl/mpt_cell.sv
// One storage cell of the rotating entry ring.
// Depends on mpt_pkg for the entry type.
module mpt_cell
    import mpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_shift_entry,
    input  logic   i_load,
    input  t_entry i_load_entry,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_load) begin
            n_entry = i_load_entry;
        end else if (i_shift) begin
            n_entry = i_shift_entry;
        end
    end

    // Only the valid bit is cleared by reset; the other fields are read for valid entries only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.addr        <= n_entry.addr;
        r_entry.ttl         <= n_entry.ttl;
        r_entry.offline     <= n_entry.offline;
        r_entry.online_time <= n_entry.online_time;
    end

    assign o_entry = r_entry;

endmodule

>>> hw/rtl/mpt_proc.sv
// Update unit at the head of the ring: applies a sighting, tick or query to one entry.
// Depends on mpt_pkg for the entry and control types.
module mpt_proc
    import mpt_pkg::*;
(
    input  t_entry     i_entry,
    input  t_proc_ctrl i_ctrl,
    output t_entry     o_entry,
    output logic       o_match
);

    logic              match;
    logic [TIME_W-1:0] time_inc;

    assign match = i_entry.valid && (i_entry.addr == i_ctrl.addr) && !i_ctrl.found;

    always_comb begin
        o_entry  = i_entry;
        o_match  = 1'b0;
        time_inc = i_entry.online_time;
        unique case (i_ctrl.op)
            OP_SIGHT: begin
                o_match = match;
                if (match) begin
                    o_entry.ttl = i_ctrl.ttl_reload;
                    if (i_entry.offline) begin
                        o_entry.offline     = 1'b0;
                        o_entry.online_time = '0;
                    end
                end
            end
            OP_TICK: begin
                if (i_entry.valid) begin
                    if (!i_entry.offline && (i_entry.online_time != TIME_MAX)) begin
                        time_inc = i_entry.online_time + 32'd1;
                    end
                    o_entry.online_time = time_inc;
                    if (i_entry.ttl <= 16'd1) begin
                        o_entry.offline     = 1'b1;
                        o_entry.online_time = '0;
                        o_entry.ttl         = i_ctrl.ttl_reload;
                    end else begin
                        o_entry.ttl = i_entry.ttl - 16'd1;
                    end
                end
            end
            OP_QUERY: begin
                o_match = match;
            end
            default: begin
                o_match = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/mac_presence_table_with_aging.sv
// Station presence table with aging: a ring of TABLE_ENTRIES cells rotated once per item.
// Each item runs a scan state, in which the ring turns past the update unit, then a done state
// that inserts a new station on a missed sighting and registers the result. Busy is high in
// both; a new item is taken only in idle, after one full turn of the ring past the single update unit.
// Reset (synchronous, active low) clears every valid bit, the insert pointer and ttl_reload
// to 60 at once. Results are not held: the receiver takes each one in its strobe cycle.
module mac_presence_table_with_aging
    import mpt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_operation,
    input  logic [ADDR_W-1:0] i_mac_addr,
    input  logic              i_cfg_we,
    input  logic [TTL_W-1:0]  i_cfg_data,
    output logic              o_valid,
    output logic              o_hit,
    output logic              o_inserted,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_is_online,
    output logic [TIME_W-1:0] o_online_time
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [IW-1:0]     r_cnt;
    logic [IW-1:0]     r_ins_ptr;
    logic [TTL_W-1:0]  r_ttl_reload;
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_addr;
    logic              r_found;
    logic [IW-1:0]     r_slot;
    logic              r_online;
    logic [TIME_W-1:0] r_time;

    logic              r_valid;
    logic              r_hit;
    logic              r_inserted;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_online;
    logic [TIME_W-1:0] r_out_time;

    t_entry     cell_q [TABLE_ENTRIES];
    t_entry     head_out;
    t_entry     ins_entry;
    t_proc_ctrl ctrl;
    logic       match;
    logic       shift;
    logic       do_insert;
    logic [IW+SLOT_W-1:0] ins_wide;
    logic [IW+SLOT_W-1:0] slot_wide;

    assign busy      = (r_state != S_IDLE);
    assign shift     = (r_state == S_SCAN);
    assign do_insert = (r_state == S_DONE) && (r_op == OP_SIGHT) && !r_found;

    assign ctrl.op         = r_op;
    assign ctrl.addr       = r_addr;
    assign ctrl.ttl_reload = r_ttl_reload;
    assign ctrl.found      = r_found;

    assign ins_entry.valid       = 1'b1;
    assign ins_entry.addr        = r_addr;
    assign ins_entry.ttl         = r_ttl_reload;
    assign ins_entry.offline     = 1'b0;
    assign ins_entry.online_time = '0;

    assign ins_wide  = {{SLOT_W{1'b0}}, r_ins_ptr};
    assign slot_wide = {{SLOT_W{1'b0}}, r_slot};

    mpt_proc u_proc (
        .i_entry (cell_q[0]),
        .i_ctrl  (ctrl),
        .o_entry (head_out),
        .o_match (match)
    );

    // The entry at cell 0 during scan step r_cnt is slot r_cnt; after a full turn
    // every entry is back in its home cell.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        t_entry shift_in;
        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign shift_in = head_out;
        end else begin : g_mid
            assign shift_in = cell_q[g+1];
        end
        mpt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (shift),
            .i_shift_entry (shift_in),
            .i_load        (do_insert && (r_ins_ptr == IW'(g))),
            .i_load_entry  (ins_entry),
            .o_entry       (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_ins_ptr    <= '0;
            r_ttl_reload <= TTL_RESET;
            r_found      <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_ttl_reload <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_found <= 1'b1;
                    end
                    if (r_cnt == LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_valid <= (r_op == OP_SIGHT) || (r_op == OP_QUERY);
                    if (do_insert) begin
                        r_ins_ptr <= (r_ins_ptr == LAST) ? '0 : r_ins_ptr + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_op     <= i_operation;
            r_addr   <= i_mac_addr;
            r_slot   <= '0;
            r_online <= 1'b0;
            r_time   <= '0;
        end else if (shift && match) begin
            r_slot   <= r_cnt;
            r_online <= !head_out.offline;
            r_time   <= head_out.offline ? '0 : head_out.online_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            if (do_insert) begin
                r_hit        <= 1'b0;
                r_inserted   <= 1'b1;
                r_out_slot   <= ins_wide[SLOT_W-1:0];
                r_out_online <= 1'b1;
                r_out_time   <= '0;
            end else begin
                r_hit        <= r_found;
                r_inserted   <= 1'b0;
                r_out_slot   <= slot_wide[SLOT_W-1:0];
                r_out_online <= r_online;
                r_out_time   <= r_time;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_inserted    = r_inserted;
    assign o_slot        = r_out_slot;
    assign o_is_online   = r_out_online;
    assign o_online_time = r_out_time;

endmodule

>>> sim/tb_mac_presence_table_with_aging.sv
// Self-checking testbench for the station presence table with aging.
// Holds a shadow copy of the table that predicts each sighting and query result;
// depends on mpt_pkg and mac_presence_table_with_aging.
module tb_mac_presence_table_with_aging;
    import mpt_pkg::*;

    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int unsigned ITEM_LATENCY   = TABLE_ENTRIES_DEF + 1;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PHASE_ITEMS    = 180;

    typedef struct packed {
        logic              hit;
        logic              inserted;
        logic [SLOT_W-1:0] slot;
        logic              is_online;
        logic [TIME_W-1:0] online_time;
    } station_report_t;

    // Shadow of the table contents and the queue of reports still owed by the block.
    class presence_table_shadow;
        bit              entry_used [TABLE_ENTRIES_DEF];
        bit [ADDR_W-1:0] entry_mac  [TABLE_ENTRIES_DEF];
        bit [TTL_W-1:0]  entry_ttl  [TABLE_ENTRIES_DEF];
        bit              entry_off  [TABLE_ENTRIES_DEF];
        bit [TIME_W-1:0] entry_time [TABLE_ENTRIES_DEF];
        int unsigned     next_slot;
        bit [TTL_W-1:0]  ttl_reload;
        station_report_t expected_reports [$];
        int unsigned     mismatches;

        function new();
            next_slot  = 0;
            ttl_reload = TTL_RESET;
            mismatches = 0;
        endfunction

        function void set_ttl(logic [TTL_W-1:0] value);
            ttl_reload = value;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function int find_station(logic [ADDR_W-1:0] mac);
            for (int k = 0; k < TABLE_ENTRIES_DEF; k++)
                if (entry_used[k] && entry_mac[k] == mac)
                    return k;
            return -1;
        endfunction

        function void note_item(logic [1:0] op, logic [ADDR_W-1:0] mac);
            int k;
            station_report_t rep;
            rep = '0;
            case (op)
                OP_SIGHT: begin
                    k = find_station(mac);
                    if (k >= 0) begin
                        entry_ttl[k] = ttl_reload;
                        // A returning station restarts its online time.
                        if (entry_off[k]) begin
                            entry_off[k]  = 1'b0;
                            entry_time[k] = '0;
                        end
                        rep.hit         = 1'b1;
                        rep.slot        = SLOT_W'(k);
                        rep.online_time = entry_time[k];
                    end else begin
                        k = next_slot;
                        entry_used[k] = 1'b1;
                        entry_mac[k]  = mac;
                        entry_ttl[k]  = ttl_reload;
                        entry_off[k]  = 1'b0;
                        entry_time[k] = '0;
                        next_slot     = (next_slot + 1) % TABLE_ENTRIES_DEF;
                        rep.inserted  = 1'b1;
                        rep.slot      = SLOT_W'(k);
                    end
                    rep.is_online = 1'b1;
                    expected_reports.push_back(rep);
                end
                OP_TICK: begin
                    // Entries are independent, so aging and countdown may share one pass.
                    foreach (entry_used[i]) begin
                        if (entry_used[i]) begin
                            if (!entry_off[i] && entry_time[i] != TIME_MAX)
                                entry_time[i]++;
                            if (entry_ttl[i] <= 1) begin
                                entry_off[i]  = 1'b1;
                                entry_time[i] = '0;
                                entry_ttl[i]  = ttl_reload;
                            end else begin
                                entry_ttl[i]--;
                            end
                        end
                    end
                end
                OP_QUERY: begin
                    k = find_station(mac);
                    if (k >= 0) begin
                        rep.hit         = 1'b1;
                        rep.slot        = SLOT_W'(k);
                        rep.is_online   = !entry_off[k];
                        rep.online_time = entry_off[k] ? '0 : entry_time[k];
                    end
                    expected_reports.push_back(rep);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(station_report_t got);
            station_report_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("inserted", want.inserted, got.inserted);
            compare_field("slot", want.slot, got.slot);
            compare_field("is_online", want.is_online, got.is_online);
            compare_field("online_time", want.online_time, got.online_time);
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic [1:0]        i_operation   = OP_SIGHT;
    logic [ADDR_W-1:0] i_mac_addr    = '0;
    logic              i_cfg_we      = 1'b0;
    logic [TTL_W-1:0]  i_cfg_data    = '0;
    logic              busy;
    logic              o_valid;
    logic              o_hit;
    logic              o_inserted;
    logic [SLOT_W-1:0] o_slot;
    logic              o_is_online;
    logic [TIME_W-1:0] o_online_time;

    presence_table_shadow shadow;
    int unsigned          stall_count = 0;

    mac_presence_table_with_aging dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_mac_addr    (i_mac_addr),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_inserted    (o_inserted),
        .o_slot        (o_slot),
        .o_is_online   (o_is_online),
        .o_online_time (o_online_time)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            shadow.check_report({o_hit, o_inserted, o_slot, o_is_online, o_online_time});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    initial begin
        wait (stall_count >= WATCHDOG_LIMIT);
        $display("%0t: no item or result accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken, with start
    // still high so that a following item in the same burst goes straight on.
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] mac);
        start       <= 1'b1;
        i_operation <= op;
        i_mac_addr  <= mac;
        do @(posedge i_clk); while (busy !== 1'b0);
        shadow.note_item(op, mac);
    endtask

    // Waits for every owed report, then long enough for a tick still in progress to end.
    task automatic settle_table();
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (ITEM_LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [TTL_W-1:0] value);
        settle_table();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        shadow.set_ttl(value);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly sightings and queries of a small set of stations so that hits, aging and
    // eviction all occur; a share of fresh addresses and unused codes as noise.
    task automatic run_traffic(input int unsigned n_items);
        logic [ADDR_W-1:0] pool [$];
        int unsigned sent, burst, gap, roll, pool_size;
        pool_size = $urandom_range(0, 1) ? $urandom_range(4, 40) : $urandom_range(41, 110);
        repeat (pool_size) pool.push_back(random_mac());
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    send_item(OP_SIGHT, pool[$urandom_range(0, pool_size - 1)]);
                else if (roll < 50)
                    send_item(OP_SIGHT, random_mac());
                else if (roll < 68)
                    send_item(OP_TICK, random_mac());
                else if (roll < 90)
                    send_item(OP_QUERY, pool[$urandom_range(0, pool_size - 1)]);
                else if (roll < 98)
                    send_item(OP_QUERY, random_mac());
                else
                    send_item(OP_UNUSED, random_mac());
                if (roll < 98)
                    sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        shadow = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, first inserts at the extremes of the address, hits and online time.
        send_item(OP_QUERY, '0);
        send_item(OP_SIGHT, '0);
        send_item(OP_SIGHT, '1);
        send_item(OP_SIGHT, '0);
        send_item(OP_TICK, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_QUERY, '1);
        send_item(OP_QUERY, 48'hAAAA_AAAA_AAAA);
        send_item(OP_SIGHT, 48'h5555_5555_5555);
        send_item(OP_TICK, '1);
        send_item(OP_SIGHT, '1);
        // The unused code must leave the table alone.
        send_item(OP_UNUSED, 48'hAAAA_AAAA_AAAA);
        send_item(OP_QUERY, 48'hAAAA_AAAA_AAAA);

        run_traffic(PHASE_ITEMS);

        // Short time-to-live: a station goes offline, its time-to-live keeps counting down, then it returns.
        reconfigure(16'd2);
        send_item(OP_SIGHT, '0);
        send_item(OP_TICK, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_TICK, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_TICK, '0);
        send_item(OP_SIGHT, '0);
        send_item(OP_TICK, '0);
        send_item(OP_QUERY, '0);

        reconfigure(16'd1);
        run_traffic(PHASE_ITEMS);
        reconfigure(16'hFFFF);
        run_traffic(PHASE_ITEMS);
        reconfigure(16'd5);
        run_traffic(PHASE_ITEMS);
        reconfigure(16'd3);
        run_traffic(PHASE_ITEMS);
        reconfigure(16'd12);
        run_traffic(PHASE_ITEMS);

        settle_table();
        if (shadow.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, shadow.pending());
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mpt_pkg.sv
hw/rtl/mpt_cell.sv
hw/rtl/mpt_proc.sv
hw/rtl/mac_presence_table_with_aging.sv
sim/tb_mac_presence_table_with_aging.sv
